@@ sv/gamma_curve_voltage_map_macros.svh @@
// Assertion helpers; expect clk and arst_n in scope.
`ifndef GAMMA_CURVE_VOLTAGE_MAP_MACROS_SVH
`define GAMMA_CURVE_VOLTAGE_MAP_MACROS_SVH

// Same-cycle implication.
`define GCVM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GCVM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/gcvm_pkg.sv @@
package gcvm_pkg;

	localparam int Q_BITS        = 16;
	localparam int Y_BITS        = 31;
	localparam int FRAC_SHIFT    = 30;
	localparam int LZ_BITS       = 5;
	localparam int GAMMA_BITS    = 15;
	localparam int GAMMA_FRAC    = 12;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int RESET_MV      = 3300;
	localparam int SHIFT_LIMIT   = 31;

	localparam logic [GAMMA_BITS-1:0] GAMMA_ONE = GAMMA_BITS'(4096);
	localparam logic [Y_BITS-1:0]     Q30_ONE   = Y_BITS'(1) << FRAC_SHIFT;

	localparam logic [CFG_IDX_BITS-1:0] REG_LOWER = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_UPPER = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_SPAN  = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_FULL  = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_GAMMA = CFG_IDX_BITS'(4);

	typedef enum logic [1:0] {
		MODE_CALC,
		MODE_ZERO,
		MODE_FULL
	} mode_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res  = '0;
		bitv = 64'd1 << 62;
		rem  = v;
		for (int k = 0; k < 32; k++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-n) in Q1.30 by repeated square roots of one half
	function automatic logic [Y_BITS-1:0] exp_root(input int n);
		logic [63:0] r;
		r = 64'd1 << (FRAC_SHIFT - 1);
		for (int k = 0; k < n; k++) begin
			r = isqrt64(r << FRAC_SHIFT);
		end
		return r[Y_BITS-1:0];
	endfunction

endpackage

@@ sv/gcvm_div.sv @@
module gcvm_div
	import gcvm_pkg::*;
#(
	parameter int MV_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               i_valid,
	output logic               i_ready,
	input  mode_t              i_mode,
	input  logic [MV_BITS-1:0] i_diff,
	input  logic [MV_BITS-1:0] span,
	output logic               o_valid,
	input  logic               o_ready,
	output mode_t              o_mode,
	output logic [Q_BITS-1:0]  o_q
);

	logic               valid_s [Q_BITS];
	logic               en      [Q_BITS];
	mode_t              mode_s  [Q_BITS];
	logic [MV_BITS-1:0] rem_s   [Q_BITS];
	logic [Q_BITS-1:0]  q_s     [Q_BITS];

	for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
		logic               vin;
		mode_t              min;
		logic [MV_BITS-1:0] rin;
		logic [Q_BITS-1:0]  qin;
		logic [MV_BITS:0]   t;
		logic [MV_BITS:0]   td;
		logic               ge;

		if (k == 0) begin : g_first
			assign vin = i_valid;
			assign min = i_mode;
			assign rin = i_diff;
			assign qin = '0;
		end else begin : g_next
			assign vin = valid_s[k-1];
			assign min = mode_s[k-1];
			assign rin = rem_s[k-1];
			assign qin = q_s[k-1];
		end

		if (k == Q_BITS - 1) begin : g_last
			assign en[k] = !valid_s[k] || o_ready;
		end else begin : g_mid
			assign en[k] = !valid_s[k] || en[k+1];
		end

		assign t  = {rin, 1'b0};
		assign ge = t >= {1'b0, span};
		assign td = t - {1'b0, span};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				mode_s[k] <= min;
				rem_s[k]  <= ge ? td[MV_BITS-1:0] : t[MV_BITS-1:0];
				q_s[k]    <= {qin[Q_BITS-2:0], ge};
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = valid_s[Q_BITS-1];
	assign o_mode  = mode_s[Q_BITS-1];
	assign o_q     = q_s[Q_BITS-1];

endmodule

@@ sv/gcvm_log.sv @@
module gcvm_log
	import gcvm_pkg::*;
#(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              i_valid,
	output logic                              i_ready,
	input  mode_t                             i_mode,
	input  logic [Q_BITS-1:0]                 i_q,
	output logic                              o_valid,
	input  logic                              o_ready,
	output mode_t                             o_mode,
	output logic [LZ_BITS+LOG_TABLE_BITS-1:0] o_log
);

	localparam int N  = LOG_TABLE_BITS + 2;
	localparam int LB = LZ_BITS + LOG_TABLE_BITS;

	logic                      valid_s [N];
	logic                      en      [N];
	mode_t                     mode_s  [N];
	logic [Y_BITS-1:0]         y_s     [N];
	logic [LOG_TABLE_BITS-1:0] frac_s  [N];
	logic [LZ_BITS-1:0]        lz_s    [N];
	logic [LB-1:0]             log_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic                      vin;
		mode_t                     mnx;
		logic [Y_BITS-1:0]         ynx;
		logic [LOG_TABLE_BITS-1:0] fnx;
		logic [LZ_BITS-1:0]        lznx;
		logic [LB-1:0]             lognx;

		if (k == 0) begin : g_norm
			logic [LZ_BITS-1:0] msb;
			assign vin = i_valid;
			always_comb begin
				msb = '0;
				for (int i = 0; i < Q_BITS; i++) begin
					if (i_q[i]) begin
						msb = LZ_BITS'(i);
					end
				end
			end
			assign mnx   = (i_mode == MODE_CALC && i_q == '0) ? MODE_ZERO : i_mode;
			assign ynx   = Y_BITS'(i_q) << (LZ_BITS'(FRAC_SHIFT) - msb);
			assign fnx   = '0;
			assign lznx  = LZ_BITS'(Q_BITS) - msb;
			assign lognx = '0;
		end else if (k <= LOG_TABLE_BITS) begin : g_square
			logic [2*Y_BITS-1:0] sq;
			logic [Y_BITS:0]     ys;
			assign vin   = valid_s[k-1];
			assign sq    = y_s[k-1] * y_s[k-1];
			assign ys    = sq[FRAC_SHIFT+Y_BITS:FRAC_SHIFT];
			assign mnx   = mode_s[k-1];
			assign ynx   = ys[Y_BITS] ? ys[Y_BITS:1] : ys[Y_BITS-1:0];
			assign fnx   = {frac_s[k-1][LOG_TABLE_BITS-2:0], ys[Y_BITS]};
			assign lznx  = lz_s[k-1];
			assign lognx = '0;
		end else begin : g_sub
			assign vin   = valid_s[k-1];
			assign mnx   = mode_s[k-1];
			assign ynx   = y_s[k-1];
			assign fnx   = frac_s[k-1];
			assign lznx  = lz_s[k-1];
			assign lognx = {lz_s[k-1], {LOG_TABLE_BITS{1'b0}}} - LB'(frac_s[k-1]);
		end

		if (k == N - 1) begin : g_last
			assign en[k] = !valid_s[k] || o_ready;
		end else begin : g_mid
			assign en[k] = !valid_s[k] || en[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				mode_s[k] <= mnx;
				y_s[k]    <= ynx;
				frac_s[k] <= fnx;
				lz_s[k]   <= lznx;
				log_s[k]  <= lognx;
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = valid_s[N-1];
	assign o_mode  = mode_s[N-1];
	assign o_log   = log_s[N-1];

endmodule

@@ sv/gcvm_exp.sv @@
module gcvm_exp
	import gcvm_pkg::*;
#(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              i_valid,
	output logic                              i_ready,
	input  mode_t                             i_mode,
	input  logic [LZ_BITS+LOG_TABLE_BITS-1:0] i_log,
	input  logic [GAMMA_BITS-1:0]             gamma,
	output logic                              o_valid,
	input  logic                              o_ready,
	output mode_t                             o_mode,
	output logic [Y_BITS-1:0]                 o_p
);

	localparam int FB = LOG_TABLE_BITS + GAMMA_FRAC;
	localparam int EB = LZ_BITS + LOG_TABLE_BITS + GAMMA_BITS;
	localparam int KB = EB - FB;
	localparam int N  = FB + 2;

	logic              valid_s [N];
	logic              en      [N];
	mode_t             mode_s  [N];
	logic [EB-1:0]     e_s     [N];
	logic [Y_BITS-1:0] v_s     [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic              vin;
		mode_t             mnx;
		logic [EB-1:0]     enx;
		logic [Y_BITS-1:0] vnx;

		if (k == 0) begin : g_mul
			logic [EB-1:0] prod;
			assign prod = EB'(i_log) * EB'(gamma);
			assign vin  = i_valid;
			assign mnx  = i_mode;
			assign enx  = prod;
			assign vnx  = Q30_ONE;
		end else if (k <= FB) begin : g_factor
			localparam logic [Y_BITS-1:0] ROOT = exp_root(k);
			logic [2*Y_BITS-1:0] pr;
			assign pr  = v_s[k-1] * ROOT;
			assign vin = valid_s[k-1];
			assign mnx = mode_s[k-1];
			assign enx = e_s[k-1];
			assign vnx = e_s[k-1][FB-k] ? pr[FRAC_SHIFT+Y_BITS-1:FRAC_SHIFT] : v_s[k-1];
		end else begin : g_shift
			logic [KB-1:0] sh;
			assign sh  = e_s[k-1][EB-1:FB];
			assign vin = valid_s[k-1];
			assign mnx = mode_s[k-1];
			assign enx = e_s[k-1];
			assign vnx = (sh >= KB'(SHIFT_LIMIT)) ? '0 : (v_s[k-1] >> sh);
		end

		if (k == N - 1) begin : g_last
			assign en[k] = !valid_s[k] || o_ready;
		end else begin : g_mid
			assign en[k] = !valid_s[k] || en[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				mode_s[k] <= mnx;
				e_s[k]    <= enx;
				v_s[k]    <= vnx;
			end
		end
	end

	assign i_ready = en[0];
	assign o_valid = valid_s[N-1];
	assign o_mode  = mode_s[N-1];
	assign o_p     = v_s[N-1];

endmodule

@@ sv/gamma_curve_voltage_map.sv @@
// channel  | handshake              | word
// ---------+------------------------+--------------------------------
// input    | in_valid / in_ready    | in_mv
// output   | out_valid / out_ready  | out_mv
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A word enters per cycle while in_ready is high and passes the input register,
// the 16 divider steps, the log squaring chain, the exp2 factor chain and out_mv_q.
// arst_n clears all valid bits and loads the register defaults.
// Each stage advances when it is empty or the next stage takes its word, so
// bubbles close up under an output stall. cfg_ready is always high.
`include "gamma_curve_voltage_map_macros.svh"

module gamma_curve_voltage_map
	import gcvm_pkg::*;
#(
	parameter int MV_BITS        = 12,
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [MV_BITS-1:0]       in_mv,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [MV_BITS-1:0]       out_mv,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int LB = LZ_BITS + LOG_TABLE_BITS;
	localparam int PB = Y_BITS + MV_BITS + 1;
	localparam logic [MV_BITS-1:0] RST_MV = MV_BITS'(RESET_MV);
	localparam logic [PB-1:0]      HALF   = PB'(1) << (FRAC_SHIFT - 1);

	logic [MV_BITS-1:0]    lower_q, upper_q, span_q, full_q;
	logic [GAMMA_BITS-1:0] gamma_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= RST_MV;
			span_q  <= RST_MV;
			full_q  <= RST_MV;
			gamma_q <= GAMMA_ONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOWER: lower_q <= cfg_data[MV_BITS-1:0];
				REG_UPPER: upper_q <= cfg_data[MV_BITS-1:0];
				REG_SPAN:  span_q  <= cfg_data[MV_BITS-1:0];
				REG_FULL:  full_q  <= cfg_data[MV_BITS-1:0];
				REG_GAMMA: gamma_q <= cfg_data[GAMMA_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic               valid_s1;
	mode_t              mode_s1;
	logic [MV_BITS-1:0] diff_s1;
	logic               en_s1;
	mode_t              mode_nx;
	logic [MV_BITS-1:0] diff_nx;

	logic                     div_ready, div_valid, log_ready, log_valid;
	logic                     exp_ready, exp_valid;
	mode_t                    div_mode, log_mode, exp_mode;
	logic [Q_BITS-1:0]        div_q;
	logic [LB-1:0]            log_val;
	logic [Y_BITS-1:0]        exp_p;

	assign diff_nx = in_mv - lower_q;

	always_comb begin
		priority if (span_q == '0) begin
			mode_nx = MODE_ZERO;
		end else if (in_mv <= lower_q) begin
			mode_nx = MODE_ZERO;
		end else if (in_mv >= upper_q) begin
			mode_nx = MODE_FULL;
		end else if (gamma_q == '0 || diff_nx >= span_q) begin
			mode_nx = MODE_FULL;
		end else begin
			mode_nx = MODE_CALC;
		end
	end

	assign en_s1    = !valid_s1 || div_ready;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1 <= mode_nx;
			diff_s1 <= diff_nx;
		end
	end

	gcvm_div #(.MV_BITS(MV_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (valid_s1),
		.i_ready (div_ready),
		.i_mode  (mode_s1),
		.i_diff  (diff_s1),
		.span    (span_q),
		.o_valid (div_valid),
		.o_ready (log_ready),
		.o_mode  (div_mode),
		.o_q     (div_q)
	);

	gcvm_log #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (div_valid),
		.i_ready (log_ready),
		.i_mode  (div_mode),
		.i_q     (div_q),
		.o_valid (log_valid),
		.o_ready (exp_ready),
		.o_mode  (log_mode),
		.o_log   (log_val)
	);

	logic out_en;

	gcvm_exp #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_exp (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (log_valid),
		.i_ready (exp_ready),
		.i_mode  (log_mode),
		.i_log   (log_val),
		.gamma   (gamma_q),
		.o_valid (exp_valid),
		.o_ready (out_en),
		.o_mode  (exp_mode),
		.o_p     (exp_p)
	);

	logic               out_valid_q;
	logic [MV_BITS-1:0] out_mv_q;
	logic [PB-1:0]      scaled;
	logic [MV_BITS+1:0] rounded;
	logic [MV_BITS-1:0] out_nx;

	assign out_en  = !out_valid_q || out_ready;
	assign scaled  = PB'(exp_p) * PB'(full_q) + HALF;
	assign rounded = scaled[FRAC_SHIFT+MV_BITS+1:FRAC_SHIFT];

	always_comb begin
		unique case (exp_mode)
			MODE_ZERO: out_nx = '0;
			MODE_FULL: out_nx = full_q;
			MODE_CALC: out_nx = (rounded > (MV_BITS+2)'(full_q)) ? full_q
				: rounded[MV_BITS-1:0];
			default:   out_nx = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= exp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_mv_q <= out_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_mv    = out_mv_q;

	`GCVM_ASSERT_NOW(a_out_clamped, out_valid, out_mv <= full_q, "output above full scale")
	`GCVM_ASSERT_NEXT(a_span_zero, in_valid && in_ready && span_q == '0, valid_s1 && mode_s1 == MODE_ZERO, "zero span not forced to zero")
	`GCVM_ASSERT_NEXT(a_zero_out, exp_valid && out_en && exp_mode == MODE_ZERO, out_valid && out_mv == '0, "zero word not delivered as zero")

endmodule
